// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfa_pkg
// Types and fixed constants of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  localparam int FUNC_W = 3;
  localparam int PAGE_W = 16;
  localparam int CNT_W  = 17;
  localparam int STAT_W = 2;

  // Page indices are 16 bits wide, so no limit goes beyond this span.
  localparam logic [CNT_W-1:0] IDX_SPAN        = 17'd65536;
  localparam logic [CNT_W-1:0] TOTAL_PAGES_RST = 17'd65536;

  localparam logic [FUNC_W-1:0] FUNC_REQUEST   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE      = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOCK      = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESERVE   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_UNRESERVE = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOCHANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STAT_W-1:0] ST_OOM      = 2'd3;

  typedef struct packed {
    logic [PAGE_W-1:0] granted_page;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  free_pages;
    logic [CNT_W-1:0]  used_pages;
    logic [CNT_W-1:0]  reserved_pages;
  } res_t;

endpackage

// ===== rtl/bpfa_map_ram.sv =====
// ----------------------------------------------------------------------------
// bpfa_map_ram
// Page bitmap store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpfa_map_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32,
  parameter int AW    = 11
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/bpfa_out_stage.sv =====
// ----------------------------------------------------------------------------
// bpfa_out_stage
// Result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module bpfa_out_stage
  import bpfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  res_t              res,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PAGE_W-1:0] granted_page,
  output logic [STAT_W-1:0] status,
  output logic [CNT_W-1:0]  free_pages,
  output logic [CNT_W-1:0]  used_pages,
  output logic [CNT_W-1:0]  reserved_pages
);

  res_t held;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= res;
    end
  end

  assign granted_page   = held.granted_page;
  assign status         = held.status;
  assign free_pages     = held.free_pages;
  assign used_pages     = held.used_pages;
  assign reserved_pages = held.reserved_pages;

endmodule

// ===== rtl/bpfa_core.sv =====
// ----------------------------------------------------------------------------
// bpfa_core
// Sequencer: clears the bitmap after reset, then runs each in-range item as a
// read-modify-write of one map word, stepping word by word for requests.
// ----------------------------------------------------------------------------
module bpfa_core
  import bpfa_pkg::*;
#(
  parameter int NUM_PAGES     = 65536,
  parameter int MAP_WORD_BITS = 32,
  parameter int AW            = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wen,
  input  logic [CNT_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FUNC_W-1:0]        func,
  input  logic [PAGE_W-1:0]        page_index,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  logic [MAP_WORD_BITS-1:0] rd_data,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic [MAP_WORD_BITS-1:0] wr_data,
  output logic                     res_push,
  output res_t                     res,
  input  logic                     out_ready
);

  // MAP_WORD_BITS must be a power of two, which the block does not check: page offset is the low WB bits.
  localparam int W         = MAP_WORD_BITS;
  localparam int WB        = $clog2(MAP_WORD_BITS);
  localparam int MAP_WORDS = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int PW_W      = CNT_W - WB;
  localparam logic [CNT_W-1:0] LIM_CAP =
    (NUM_PAGES < 65536) ? CNT_W'(NUM_PAGES) : IDX_SPAN;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAP_WORDS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state;
  logic [AW-1:0]     clr_addr;
  logic [CNT_W-1:0]  total_pages;
  logic [FUNC_W-1:0] func_r;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  hint;
  logic [CNT_W-1:0]  taken;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  rsvd;
  logic [STAT_W-1:0] status_r;
  logic [PAGE_W-1:0] granted_r;

  logic [CNT_W-1:0]  lim;
  logic [PW_W-1:0]   pos_word;
  logic [PW_W-1:0]   lim_word;
  logic [WB-1:0]     off;
  logic [WB-1:0]     lim_off;
  logic [AW-1:0]     word_addr;
  logic [W-1:0]      lo_mask;
  logic [W-1:0]      hi_mask;
  logic [W-1:0]      cand;
  logic [W-1:0]      bit_sel;
  logic [WB-1:0]     first;
  logic              found;
  logic              setting;
  logic              cur_bit;
  logic              change;

  assign lim       = (total_pages > LIM_CAP) ? LIM_CAP : total_pages;
  assign pos_word  = pos[CNT_W-1:WB];
  assign lim_word  = lim[CNT_W-1:WB];
  assign off       = pos[WB-1:0];
  assign lim_off   = lim[WB-1:0];
  assign word_addr = AW'(pos_word);
  assign in_stall  = (state != S_IDLE);

  // Free candidates in the current word: clear bits from the scan point up
  // to, but not including, the active limit.
  always_comb begin
    lo_mask = {W{1'b1}} << off;
    hi_mask = (pos_word == lim_word) ? ~({W{1'b1}} << lim_off) : {W{1'b1}};
    cand    = ~rd_data & lo_mask & hi_mask;
    found   = |cand;
    first   = '0;
    for (int k = W - 1; k >= 0; k--) begin
      if (cand[k]) begin
        first = WB'(k);
      end
    end
  end

  always_comb begin
    bit_sel = W'(1) << off;
    setting = (func_r == FUNC_LOCK) || (func_r == FUNC_RESERVE);
    cur_bit = rd_data[off];
    change  = (cur_bit != setting);
  end

  // Map port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = word_addr;
    wr_en   = 1'b0;
    wr_addr = word_addr;
    wr_data = '0;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      S_ISSUE: begin
        rd_en = (func_r <= FUNC_UNRESERVE) && (pos < lim);
      end
      S_EVAL: begin
        if (func_r == FUNC_REQUEST) begin
          wr_en   = found;
          wr_data = rd_data | (W'(1) << first);
        end else begin
          wr_en   = change;
          wr_data = setting ? (rd_data | bit_sel) : (rd_data & ~bit_sel);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages <= TOTAL_PAGES_RST;
    end else if (cfg_wen) begin
      total_pages <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      hint     <= '0;
      taken    <= '0;
      used     <= '0;
      rsvd     <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            func_r    <= func;
            granted_r <= '0;
            pos       <= (func == FUNC_REQUEST) ? hint : {1'b0, page_index};
            state     <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (func_r > FUNC_UNRESERVE) begin
            status_r <= ST_NOCHANGE;
            state    <= S_DONE;
          end else if (pos >= lim) begin
            if (func_r == FUNC_REQUEST) begin
              // Scan ran out, or the hint was already at or past the limit.
              status_r <= ST_OOM;
              if (hint < lim) begin
                hint <= lim;
              end
            end else begin
              status_r <= ST_RANGE;
            end
            state <= S_DONE;
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (func_r == FUNC_REQUEST) begin
            if (found) begin
              hint      <= {pos_word, first};
              granted_r <= PAGE_W'({pos_word, first});
              taken     <= taken + CNT_W'(1);
              used      <= used + CNT_W'(1);
              status_r  <= ST_DONE;
              state     <= S_DONE;
            end else begin
              // Advance to the start of the next map word.
              pos   <= {pos_word + PW_W'(1), {WB{1'b0}}};
              state <= S_ISSUE;
            end
          end else begin
            state <= S_DONE;
            if (!change) begin
              status_r <= ST_NOCHANGE;
            end else begin
              status_r <= ST_DONE;
              if (setting) begin
                taken <= taken + CNT_W'(1);
                if (func_r == FUNC_LOCK) begin
                  used <= used + CNT_W'(1);
                end else begin
                  rsvd <= rsvd + CNT_W'(1);
                end
              end else begin
                taken <= taken - CNT_W'(1);
                if (func_r == FUNC_FREE) begin
                  used <= used - CNT_W'(1);
                end else begin
                  rsvd <= rsvd - CNT_W'(1);
                end
                if (hint > pos) begin
                  hint <= pos;
                end
              end
            end
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_push = (state == S_DONE) && out_ready;

  always_comb begin
    res.granted_page   = granted_r;
    res.status         = status_r;
    res.free_pages     = (lim > taken) ? (lim - taken) : '0;
    res.used_pages     = used;
    res.reserved_pages = rsvd;
  end

endmodule

// ===== rtl/bitmap_page_frame_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_top
// Bitmap page frame allocator with a next-free search hint.
//
//   channel | dir | handshake             | fields
//   --------+-----+-----------------------+-------------------------------------
//   in      | in  | in_valid / in_stall   | func, page_index
//   out     | out | out_valid / out_stall | granted_page, status, free_pages,
//           |     |                       | used_pages, reserved_pages
//   cfg     | in  | cfg_wen               | cfg_wdata (total_pages)
//
// Free, lock, reserve and unreserve step through accept, map word read,
// modify and write back, then result hand-off to the output register.
// A request repeats the read and evaluate steps for each map word scanned
// from the hint, one word at a time on the single map read port.
// Out-of-range items and unused codes skip the map read and write.
// After rst the map is cleared one word per cycle, MAP_WORDS words (2048 at
// defaults), with in_stall high; cfg writes are still taken.
// The next item is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_page_frame_allocator_top
  import bpfa_pkg::*;
#(
  parameter int NUM_PAGES     = 65536,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] func,
  input  logic [PAGE_W-1:0] page_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PAGE_W-1:0] granted_page,
  output logic [STAT_W-1:0] status,
  output logic [CNT_W-1:0]  free_pages,
  output logic [CNT_W-1:0]  used_pages,
  output logic [CNT_W-1:0]  reserved_pages
);

  localparam int MAP_WORDS = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic [MAP_WORD_BITS-1:0] rd_data;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [MAP_WORD_BITS-1:0] wr_data;
  logic                     res_push;
  logic                     out_ready;
  res_t                     res;

  bpfa_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (MAP_WORD_BITS),
    .AW    (AW)
  ) u_map (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bpfa_core #(
    .NUM_PAGES     (NUM_PAGES),
    .MAP_WORD_BITS (MAP_WORD_BITS),
    .AW            (AW)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .page_index (page_index),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .res_push   (res_push),
    .res        (res),
    .out_ready  (out_ready)
  );

  bpfa_out_stage u_out (
    .clk            (clk),
    .rst            (rst),
    .push           (res_push),
    .res            (res),
    .ready          (out_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted_page   (granted_page),
    .status         (status),
    .free_pages     (free_pages),
    .used_pages     (used_pages),
    .reserved_pages (reserved_pages)
  );

  // Read and write never hit the same map word in one cycle.
  `ASSERT_SAME(a_no_rw_collide, rd_en && wr_en, rd_addr != wr_addr, "map read/write collision")
  // The map is only written while the block is busy.
  `ASSERT_SAME(a_wr_when_busy, wr_en, in_stall, "map written while idle")
  // An accepted item makes the block busy in the next cycle.
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no busy after accept")
  // A pushed result shows up on the output channel.
  `ASSERT_NEXT(a_push_to_out, res_push, out_valid, "pushed result not presented")

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap page frame allocator. A directed table
// covers the reset state, counter wrap, no-change and unused function codes,
// then random phases run at several page limits (zero, one, small, full and
// beyond the index span). Each result is checked field by field against its
// table row or a built-in allocator model, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top
  import bpfa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 20;
  localparam int RST_CYCLES  = 11;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DIR_COUNT   = 25;
  localparam int PHASES      = 6;
  localparam int IDLE_PCT    = 19;
  localparam int LIVE_KEEP   = 64;

  // Function codes with no operation behind them.
  localparam logic [FUNC_W-1:0] FUNC_SPARE5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE7 = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic [PAGE_W-1:0] page;
    logic              typed;
    res_t              want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{FUNC_REQUEST,   16'd0,     1'b1, '{16'd0, ST_DONE,     17'd65535, 17'd1,      17'd0}},
    '{FUNC_REQUEST,   16'd0,     1'b1, '{16'd1, ST_DONE,     17'd65534, 17'd2,      17'd0}},
    '{FUNC_LOCK,      16'hFFFF,  1'b1, '{16'd0, ST_DONE,     17'd65533, 17'd3,      17'd0}},
    '{FUNC_LOCK,      16'hFFFF,  1'b1, '{16'd0, ST_NOCHANGE, 17'd65533, 17'd3,      17'd0}},
    '{FUNC_RESERVE,   16'd0,     1'b1, '{16'd0, ST_NOCHANGE, 17'd65533, 17'd3,      17'd0}},
    '{FUNC_RESERVE,   16'h8000,  1'b1, '{16'd0, ST_DONE,     17'd65532, 17'd3,      17'd1}},
    '{FUNC_UNRESERVE, 16'h8000,  1'b1, '{16'd0, ST_DONE,     17'd65533, 17'd3,      17'd0}},
    '{FUNC_UNRESERVE, 16'h8000,  1'b1, '{16'd0, ST_NOCHANGE, 17'd65533, 17'd3,      17'd0}},
    '{FUNC_FREE,      16'd0,     1'b1, '{16'd0, ST_DONE,     17'd65534, 17'd2,      17'd0}},
    '{FUNC_FREE,      16'd0,     1'b1, '{16'd0, ST_NOCHANGE, 17'd65534, 17'd2,      17'd0}},
    // unreserve a page that a request took: reserved count wraps below zero
    '{FUNC_UNRESERVE, 16'd1,     1'b1, '{16'd0, ST_DONE,     17'd65535, 17'd2,  17'd131071}},
    '{FUNC_FREE,      16'hFFFF,  1'b1, '{16'd0, ST_DONE,     17'd65536, 17'd1,  17'd131071}},
    '{FUNC_FREE,      16'd1,     1'b1, '{16'd0, ST_NOCHANGE, 17'd65536, 17'd1,  17'd131071}},
    '{FUNC_RESERVE,   16'd1,     1'b1, '{16'd0, ST_DONE,     17'd65535, 17'd1,      17'd0}},
    '{FUNC_FREE,      16'd1,     1'b1, '{16'd0, ST_DONE,     17'd65536, 17'd0,      17'd0}},
    '{FUNC_RESERVE,   16'd2,     1'b1, '{16'd0, ST_DONE,     17'd65535, 17'd0,      17'd1}},
    // free a reserved page with no used pages: used count wraps
    '{FUNC_FREE,      16'd2,     1'b1, '{16'd0, ST_DONE,     17'd65536, 17'd131071, 17'd1}},
    '{FUNC_SPARE5,    16'hFFFF,  1'b1, '{16'd0, ST_NOCHANGE, 17'd65536, 17'd131071, 17'd1}},
    '{FUNC_SPARE6,    16'd0,     1'b1, '{16'd0, ST_NOCHANGE, 17'd65536, 17'd131071, 17'd1}},
    '{FUNC_SPARE7,    16'h1234,  1'b1, '{16'd0, ST_NOCHANGE, 17'd65536, 17'd131071, 17'd1}},
    '{FUNC_REQUEST,   16'hFFFF,  1'b1, '{16'd0, ST_DONE,     17'd65535, 17'd0,      17'd1}},
    '{FUNC_LOCK,      16'hAAAA,  1'b0, '0},
    '{FUNC_RESERVE,   16'h5555,  1'b0, '0},
    '{FUNC_REQUEST,   16'h5555,  1'b0, '0},
    '{FUNC_FREE,      16'hAAAA,  1'b0, '0}
  };

  localparam logic [CNT_W-1:0] PHASE_LIMIT [PHASES] = '{
    17'd40, 17'd0, 17'd131071, 17'd1, 17'd40, 17'd65536
  };
  localparam int PHASE_ITEMS [PHASES] = '{120, 20, 150, 30, 60, 100};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wen = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] func = FUNC_REQUEST;
  logic [PAGE_W-1:0] page_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PAGE_W-1:0] granted_page;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  free_pages;
  logic [CNT_W-1:0]  used_pages;
  logic [CNT_W-1:0]  reserved_pages;

  // allocator model state
  bit               frame_busy [0:65535];
  logic [CNT_W-1:0] page_limit = TOTAL_PAGES_RST;
  logic [CNT_W-1:0] scan_hint  = '0;
  logic [CNT_W-1:0] taken_tally = '0;
  logic [CNT_W-1:0] used_tally  = '0;
  logic [CNT_W-1:0] resv_tally  = '0;

  res_t              pending_results [$];
  logic [PAGE_W-1:0] live_pages [$];
  bit                calm = 1'b0;
  int unsigned       mismatch_cnt = 0;
  int unsigned       result_no = 0;
  int unsigned       cycle_cnt = 0;

  bitmap_page_frame_allocator_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .page_index     (page_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted_page   (granted_page),
    .status         (status),
    .free_pages     (free_pages),
    .used_pages     (used_pages),
    .reserved_pages (reserved_pages)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [CNT_W-1:0] active_pages();
    return (page_limit > IDX_SPAN) ? IDX_SPAN : page_limit;
  endfunction

  // Apply one item to the model state and return the result it should give.
  function automatic res_t predict_alloc(input logic [FUNC_W-1:0] op,
                                         input logic [PAGE_W-1:0] idx);
    res_t             r;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] p;
    bit               target;
    r = '0;
    r.status = ST_NOCHANGE;
    lim = active_pages();
    case (op)
      FUNC_REQUEST: begin
        p = scan_hint;
        while (p < lim && frame_busy[p[PAGE_W-1:0]]) p = p + 1'b1;
        if (p < lim) begin
          frame_busy[p[PAGE_W-1:0]] = 1'b1;
          taken_tally = taken_tally + 1'b1;
          used_tally = used_tally + 1'b1;
          scan_hint = p;
          r.granted_page = p[PAGE_W-1:0];
          r.status = ST_DONE;
        end else begin
          if (scan_hint < lim) scan_hint = lim;
          r.status = ST_OOM;
        end
      end
      FUNC_FREE, FUNC_LOCK, FUNC_RESERVE, FUNC_UNRESERVE: begin
        target = (op == FUNC_LOCK || op == FUNC_RESERVE);
        if ({1'b0, idx} >= lim) begin
          r.status = ST_RANGE;
        end else if (frame_busy[idx] != target) begin
          frame_busy[idx] = target;
          r.status = ST_DONE;
          if (target) begin
            taken_tally = taken_tally + 1'b1;
            if (op == FUNC_LOCK) used_tally = used_tally + 1'b1;
            else resv_tally = resv_tally + 1'b1;
          end else begin
            taken_tally = taken_tally - 1'b1;
            if (op == FUNC_FREE) used_tally = used_tally - 1'b1;
            else resv_tally = resv_tally - 1'b1;
            if (scan_hint > {1'b0, idx}) scan_hint = {1'b0, idx};
          end
        end
      end
      default: ;
    endcase
    r.free_pages = (lim > taken_tally) ? lim - taken_tally : '0;
    r.used_pages = used_tally;
    r.reserved_pages = resv_tally;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $realtime, result_no, msg);
    mismatch_cnt++;
  endtask

  task automatic compare_field(input string name, input logic [CNT_W-1:0] got_v,
                               input logic [CNT_W-1:0] want_v);
    if (got_v != want_v)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got_v, want_v));
  endtask

  // Offer one item, hold it until taken, then queue its expected result.
  task automatic offer_item(input logic [FUNC_W-1:0] op, input logic [PAGE_W-1:0] idx,
                            input bit typed, input res_t want, output res_t predicted);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    page_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_alloc(op, idx);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_total_pages(input logic [CNT_W-1:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    page_limit = value;
  endtask

  // Mostly allocate and release pages that exist; a share of noise on top.
  task automatic random_item();
    logic [FUNC_W-1:0] op;
    logic [PAGE_W-1:0] idx;
    logic [CNT_W-1:0]  span;
    int unsigned       roll;
    res_t              predicted;
    span = active_pages();
    roll = $urandom_range(99);
    if (roll < 35) op = FUNC_REQUEST;
    else if (roll < 55) op = FUNC_FREE;
    else if (roll < 65) op = FUNC_LOCK;
    else if (roll < 75) op = FUNC_RESERVE;
    else if (roll < 85) op = FUNC_UNRESERVE;
    else op = FUNC_W'($urandom_range(7));
    roll = $urandom_range(99);
    if (roll < 10 || span == 0) idx = PAGE_W'($urandom_range(16'hFFFF));
    else if (roll < 60 && live_pages.size() > 0)
      idx = live_pages[$urandom_range(live_pages.size() - 1)];
    else idx = PAGE_W'($urandom_range(span - 1));
    offer_item(op, idx, 1'b0, '0, predicted);
    if (predicted.status == ST_DONE) begin
      if (op == FUNC_REQUEST) live_pages.push_back(predicted.granted_page);
      else if (op == FUNC_LOCK || op == FUNC_RESERVE) live_pages.push_back(idx);
      if (live_pages.size() > LIVE_KEEP) void'(live_pages.pop_front());
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{granted_page, status, free_pages, used_pages, reserved_pages};
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        compare_field("granted_page", CNT_W'(got.granted_page), CNT_W'(want.granted_page));
        compare_field("status", CNT_W'(got.status), CNT_W'(want.status));
        compare_field("free_pages", got.free_pages, want.free_pages);
        compare_field("used_pages", got.used_pages, want.used_pages);
        compare_field("reserved_pages", got.reserved_pages, want.reserved_pages);
      end
      result_no++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    res_t predicted;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table runs on the reset page limit
    for (int i = 0; i < DIR_COUNT; i++)
      offer_item(DIR_ROWS[i].op, DIR_ROWS[i].page, DIR_ROWS[i].typed, DIR_ROWS[i].want,
                 predicted);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      set_total_pages(PHASE_LIMIT[ph]);
      for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
        if (ph == 2) begin
          calm = (n >= 10 && n < 70);
          if (n == 75) drain_results();
        end
        random_item();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
